// File: design/depth_background_foreground_defines.svh
// Assertion macros shared by the depth background/foreground design.
`ifndef DEPTH_BACKGROUND_FOREGROUND_DEFINES_SVH
`define DEPTH_BACKGROUND_FOREGROUND_DEFINES_SVH

// Same-cycle implication, checked on aclk, off while aresetn is low.
`define DBF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk, off while aresetn is low.
`define DBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/dbf_pkg.sv
// Package with types and constants of the depth background/foreground block.
`default_nettype none
package dbf_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_LEARN  = 2'd1,
        MODE_ACTIVE = 2'd2,
        MODE_CHANGE = 2'd3
    } mode_t;

    localparam int DEPTH_W  = 16;
    localparam int MASK_W   = 8;
    localparam int DIM_W    = 10;
    localparam int CUT_W    = 13;
    localparam int OFF_W    = 9;
    localparam int RNG_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE  = 3'd5;

    localparam logic [DIM_W-1:0]   RST_WIDTH  = 10'd512;
    localparam logic [DIM_W-1:0]   RST_HEIGHT = 10'd424;
    localparam logic [CUT_W-1:0]   RST_CUTOFF = 13'd4000;
    localparam logic [OFF_W-1:0]   RST_OFFSET = 9'd10;
    localparam logic [RNG_W-1:0]   RST_RANGE  = 13'd1000;

    localparam logic [MASK_W-1:0]  MASK_THRESHOLD = 8'd128;
    localparam logic [DEPTH_W-1:0] BG_CLEARED     = 16'hFFFF;

endpackage
`default_nettype wire

// File: design/dbf_bg_ram.sv
// Single-port-write, single-port-read background depth memory, registered read.
`default_nettype none
module dbf_bg_ram
    import dbf_pkg::*;
#(
    parameter int DEPTH = 262144,
    parameter int AW    = 18
) (
    input  wire logic               aclk,
    input  wire logic               rd_en,
    input  wire logic [AW-1:0]      rd_addr,
    output logic      [DEPTH_W-1:0] rd_data,
    input  wire logic               wr_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire logic [DEPTH_W-1:0] wr_data
);

    logic [DEPTH_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read at the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: design/dbf_frame_ctr.sv
// Pixel address counter with frame size clamping, wrap and frame start resync.
`default_nettype none
module dbf_frame_ctr
    import dbf_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int AW         = 18
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [DIM_W-1:0] cfg_width,
    input  wire logic [DIM_W-1:0] cfg_height,
    input  wire logic             advance,
    input  wire logic             frame_start,
    output logic      [AW-1:0]    pix_addr,
    output logic                  pix_last
);

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int CH    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int SW    = $clog2(DEPTH + 1);

    logic [CW-1:0] w_clamp;
    logic [CH-1:0] h_clamp;
    logic [SW-1:0] frame_size;
    logic [AW-1:0] addr_sel;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;

    always_comb begin
        if (cfg_width == '0) begin
            w_clamp = CW'(1);
        end else if (int'(cfg_width) > MAX_WIDTH) begin
            w_clamp = CW'(MAX_WIDTH);
        end else begin
            w_clamp = CW'(cfg_width);
        end
        if (cfg_height == '0) begin
            h_clamp = CH'(1);
        end else if (int'(cfg_height) > MAX_HEIGHT) begin
            h_clamp = CH'(MAX_HEIGHT);
        end else begin
            h_clamp = CH'(cfg_height);
        end
    end

    assign frame_size = SW'(w_clamp) * SW'(h_clamp);

    // A counter left beyond a shrunken frame restarts at the first pixel.
    always_comb begin
        addr_sel = frame_start ? '0 : cnt_reg;
        if (SW'(addr_sel) >= frame_size) begin
            pix_addr = '0;
        end else begin
            pix_addr = addr_sel;
        end
        pix_last = (SW'(pix_addr) == frame_size - SW'(1));
        cnt_next = pix_last ? '0 : pix_addr + AW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (advance) begin
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// File: design/dbf_pixel_eval.sv
// Per-pixel background update and foreground decision for all four modes.
`default_nettype none
module dbf_pixel_eval
    import dbf_pkg::*;
(
    input  wire mode_t              mode,
    input  wire logic [DEPTH_W-1:0] depth,
    input  wire logic [MASK_W-1:0]  mask_level,
    input  wire logic [DEPTH_W-1:0] bg_old,
    input  wire logic [CUT_W-1:0]   near_cutoff,
    input  wire logic [OFF_W-1:0]   bg_offset,
    input  wire logic [RNG_W-1:0]   range_depth,
    output logic      [DEPTH_W-1:0] bg_new,
    output logic                    foreground
);

    logic signed [19:0] d_s;
    logic signed [19:0] bg_s;
    logic signed [19:0] cut_s;
    logic signed [19:0] off_s;
    logic signed [19:0] thr_hi;
    logic signed [19:0] thr_lo;
    logic signed [19:0] diff;
    logic signed [19:0] diff_abs;
    logic               valid_depth;

    assign d_s    = $signed({4'b0, depth});
    assign bg_s   = $signed({4'b0, bg_old});
    assign cut_s  = $signed({7'b0, near_cutoff});
    assign off_s  = $signed({11'b0, bg_offset});
    assign thr_hi = bg_s - off_s;
    assign thr_lo = thr_hi - $signed({7'b0, range_depth});
    assign diff   = d_s - bg_s;
    assign diff_abs = diff[19] ? -diff : diff;
    assign valid_depth = d_s > cut_s;

    always_comb begin
        bg_new     = bg_old;
        foreground = 1'b0;
        case (mode)
            MODE_CLEAR: begin
                bg_new = BG_CLEARED;
            end
            MODE_LEARN: begin
                if (valid_depth && d_s < bg_s) begin
                    bg_new = depth;
                end
            end
            MODE_ACTIVE: begin
                foreground = (d_s < thr_hi) && (d_s > thr_lo) && valid_depth
                             && (mask_level > MASK_THRESHOLD);
            end
            MODE_CHANGE: begin
                foreground = diff_abs >= off_s;
            end
            default: begin
                bg_new = bg_old;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: design/depth_background_foreground.sv
// Top level of the depth background/foreground block: config, pipeline, memory.
//
//   Port group  Direction  Content
//   s_*         in         depth pixel: tdata depth, mask_level; tuser frame_start
//   m_*         out        result: tdata background; tuser foreground; tlast frame_end
//   cfg_*       in         register write: cfg_we, cfg_index, cfg_wdata
//
// One pixel per clock is accepted while the output is not stalled; a result passes
// through stage 1, which takes the memory's registered read, and the output register.
// Each pixel reads the background memory and, in clear and learn modes, writes it
// back; a write-back to the address the next pixel reads is forwarded to it.
// Reset clears control state only: the background memory holds nothing valid
// until a frame has passed in clear mode. A stalled output holds the stage behind it.
`default_nettype none
module depth_background_foreground
    import dbf_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,   // [15:0] depth, [23:16] mask_level
    input  wire logic                  s_tuser,   // [0] frame_start
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [15:0]           m_tdata,   // [15:0] background
    output logic                       m_tuser,   // [0] foreground
    output logic                       m_tlast,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "depth_background_foreground_defines.svh"

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mode_t            mode_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [CUT_W-1:0] cutoff_reg;
    logic [OFF_W-1:0] offset_reg;
    logic [RNG_W-1:0] range_reg;

    logic               accept;
    logic               p1_adv;
    logic               mem_we;
    logic [AW-1:0]      pix_addr;
    logic               pix_last;
    logic [DEPTH_W-1:0] rd_data;
    logic [DEPTH_W-1:0] bg_cur;
    logic [DEPTH_W-1:0] bg_new;
    logic               fg;

    logic               p1_valid_reg;
    logic [DEPTH_W-1:0] p1_depth_reg;
    logic [MASK_W-1:0]  p1_mask_reg;
    logic [AW-1:0]      p1_addr_reg;
    logic               p1_last_reg;
    logic               fwd_reg;
    logic [DEPTH_W-1:0] fwd_data_reg;

    logic               m_tvalid_reg;
    logic [DEPTH_W-1:0] m_bg_reg;
    logic               m_fg_reg;
    logic               m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_LEARN;
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            cutoff_reg <= RST_CUTOFF;
            offset_reg <= RST_OFFSET;
            range_reg  <= RST_RANGE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MODE:   mode_reg   <= mode_t'(cfg_wdata[1:0]);
                REG_WIDTH:  width_reg  <= cfg_wdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_wdata[DIM_W-1:0];
                REG_CUTOFF: cutoff_reg <= cfg_wdata[CUT_W-1:0];
                REG_OFFSET: offset_reg <= cfg_wdata[OFF_W-1:0];
                REG_RANGE:  range_reg  <= cfg_wdata[RNG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign p1_adv   = p1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p1_adv;
    assign accept   = s_tvalid && s_tready;
    assign mem_we   = p1_adv && (mode_reg == MODE_CLEAR || mode_reg == MODE_LEARN);

    dbf_frame_ctr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_frame_ctr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_width   (width_reg),
        .cfg_height  (height_reg),
        .advance     (accept),
        .frame_start (s_tuser),
        .pix_addr    (pix_addr),
        .pix_last    (pix_last)
    );

    dbf_bg_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bg_ram (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (pix_addr),
        .rd_data (rd_data),
        .wr_en   (mem_we),
        .wr_addr (p1_addr_reg),
        .wr_data (bg_new)
    );

    assign bg_cur = fwd_reg ? fwd_data_reg : rd_data;

    dbf_pixel_eval u_pixel_eval (
        .mode        (mode_reg),
        .depth       (p1_depth_reg),
        .mask_level  (p1_mask_reg),
        .bg_old      (bg_cur),
        .near_cutoff (cutoff_reg),
        .bg_offset   (offset_reg),
        .range_depth (range_reg),
        .bg_new      (bg_new),
        .foreground  (fg)
    );

    // Stage 1: the pixel waits here for its memory read; the write-back happens
    // as it moves to the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            if (accept) begin
                p1_valid_reg <= 1'b1;
                fwd_reg      <= p1_adv && (pix_addr == p1_addr_reg);
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
                fwd_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_depth_reg <= s_tdata[15:0];
            p1_mask_reg  <= s_tdata[23:16];
            p1_addr_reg  <= pix_addr;
            p1_last_reg  <= pix_last;
            fwd_data_reg <= bg_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (p1_adv) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            m_bg_reg   <= bg_new;
            m_fg_reg   <= fg;
            m_last_reg <= p1_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_bg_reg;
    assign m_tuser  = m_fg_reg;
    assign m_tlast  = m_last_reg;

    `DBF_ASSERT_SAME(a_ready_when_empty, !p1_valid_reg, s_tready, "stage 1 empty but input not ready")
    `DBF_ASSERT_SAME(a_fwd_has_item, fwd_reg, p1_valid_reg, "forward flag set without a pixel in stage 1")
    `DBF_ASSERT_SAME(a_write_mode, mem_we, (mode_reg == MODE_CLEAR || mode_reg == MODE_LEARN), "background written in a detect mode")
    `DBF_ASSERT_NEXT(a_adv_loads_out, p1_adv, m_tvalid_reg, "advanced pixel did not reach the output")
    `DBF_ASSERT_SAME(a_fg_detect_only, m_tvalid_reg && m_fg_reg, (mode_reg == MODE_ACTIVE || mode_reg == MODE_CHANGE), "foreground flagged outside a detect mode")

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench of the depth background/foreground block.
`timescale 1ns / 100ps

module tb_top;
    import dbf_pkg::*;

    localparam int MAX_W      = 512;
    localparam int MAX_H      = 512;
    localparam int STORE_N    = MAX_W * MAX_H;
    localparam int CYCLE_CAP  = 1000000;
    localparam int DRAIN_WAIT = 10;
    localparam int RAND_PHASES     = 17;
    localparam int ITEMS_PER_PHASE = 50;

    typedef struct packed {
        bit        fg;
        bit [15:0] bg;
        bit        last;
    } px_result_t;

    // Mirrors the block: background store, pixel counter and registers, and
    // holds the results still owed by the block.
    class fg_scoreboard;
        bit [15:0]   bg_mem [STORE_N];
        bit          bg_known [STORE_N];
        int unsigned pix_cnt;
        mode_t       cur_mode;
        bit [9:0]    width;
        bit [9:0]    height;
        bit [12:0]   cutoff;
        bit [8:0]    offset;
        bit [12:0]   range_d;
        px_result_t  expected_px [$];
        int          mismatches;

        function new();
            pix_cnt    = 0;
            cur_mode   = MODE_LEARN;
            width      = RST_WIDTH;
            height     = RST_HEIGHT;
            cutoff     = RST_CUTOFF;
            offset     = RST_OFFSET;
            range_d    = RST_RANGE;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_MODE:   cur_mode = mode_t'(val[1:0]);
                REG_WIDTH:  width    = val[9:0];
                REG_HEIGHT: height   = val[9:0];
                REG_CUTOFF: cutoff   = val[12:0];
                REG_OFFSET: offset   = val[8:0];
                REG_RANGE:  range_d  = val[12:0];
                default: ;
            endcase
        endfunction

        function int unsigned frame_size();
            int unsigned w;
            int unsigned h;
            w = (width == 0) ? 1 : (width > MAX_W) ? MAX_W : width;
            h = (height == 0) ? 1 : (height > MAX_H) ? MAX_H : height;
            return w * h;
        endfunction

        function int unsigned addr_of(bit start);
            int unsigned a;
            a = start ? 0 : pix_cnt;
            if (a >= frame_size()) a = 0;
            return a;
        endfunction

        // True when every entry of the current frame has been cleared once.
        function bit frame_ready();
            for (int unsigned i = 0; i < frame_size(); i++)
                if (!bg_known[i]) return 1'b0;
            return 1'b1;
        endfunction

        function int pending();
            return expected_px.size();
        endfunction

        function void pixel_accepted(bit [15:0] depth, bit [7:0] mask, bit start);
            int unsigned addr;
            int unsigned size;
            int          d;
            int          bg;
            int          cut;
            int          off;
            int          rng;
            int          diff;
            px_result_t  r;
            size = frame_size();
            addr = addr_of(start);
            d    = int'(depth);
            bg   = int'(bg_mem[addr]);
            cut  = int'(cutoff);
            off  = int'(offset);
            rng  = int'(range_d);
            r.fg = 1'b0;
            case (cur_mode)
                MODE_CLEAR: begin
                    bg_mem[addr]   = BG_CLEARED;
                    bg_known[addr] = 1'b1;
                end
                MODE_LEARN: begin
                    if (d > cut && d < bg) bg_mem[addr] = depth;
                end
                MODE_ACTIVE: begin
                    r.fg = (d < bg - off) && (d > bg - off - rng) && (d > cut) &&
                           (mask > MASK_THRESHOLD);
                end
                default: begin
                    diff = d - bg;
                    if (diff < 0) diff = -diff;
                    r.fg = (diff >= off);
                end
            endcase
            r.last  = (addr == size - 1);
            r.bg    = bg_mem[addr];
            pix_cnt = r.last ? 0 : addr + 1;
            expected_px.push_back(r);
        endfunction

        function void result_seen(logic fg, logic [15:0] bg, logic last);
            px_result_t want;
            if (expected_px.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: fg=%0b bg=%h last=%0b", fg, bg, last);
                return;
            end
            want = expected_px.pop_front();
            if (want.fg !== fg || want.bg !== bg || want.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected fg=%0b bg=%h last=%0b, got fg=%0b bg=%h last=%0b",
                             want.fg, want.bg, want.last, fg, bg, last);
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    fg_scoreboard          sb;
    int                    idle_pct  = 0;
    int                    stall_pct = 0;
    int                    cycle_count = 0;
    logic [CFG_DATA_W-1:0] reg_shadow [6];

    depth_background_foreground #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("FAIL depth_background_foreground");
            $finish;
        end
    end

    // Result side: check every accepted transaction and stall at random.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.result_seen(m_tuser, m_tdata, m_tlast);
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_pixel(bit [15:0] depth, bit [7:0] mask, bit start);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mask, depth};
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.pixel_accepted(depth, mask, start);
    endtask

    // Hold the input off until the block has delivered everything it owes.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        if (reg_shadow[idx] == val) return;
        reg_shadow[idx] = val;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    // Reprogram the block while idle; a detect or learn phase first gets a clear
    // frame when part of the frame's store was never cleared.
    task automatic apply_settings(mode_t m, logic [CFG_DATA_W-1:0] w,
                                  logic [CFG_DATA_W-1:0] h, logic [CFG_DATA_W-1:0] cut,
                                  logic [CFG_DATA_W-1:0] off, logic [CFG_DATA_W-1:0] rng);
        logic [10:0] hi;
        hi = ($urandom_range(4) == 0) ? 11'($urandom_range(2047)) : 11'd0;
        wait_idle();
        set_reg(REG_WIDTH, w);
        set_reg(REG_HEIGHT, h);
        set_reg(REG_CUTOFF, cut);
        set_reg(REG_OFFSET, off);
        set_reg(REG_RANGE, rng);
        if (m != MODE_CLEAR && !sb.frame_ready()) begin
            set_reg(REG_MODE, {11'd0, MODE_CLEAR});
            for (int i = 0; i < int'(sb.frame_size()); i++)
                send_pixel(16'($urandom), 8'($urandom), i == 0);
            wait_idle();
        end
        set_reg(REG_MODE, {hi, m});
    endtask

    // Depths are mostly placed around the edges of the decision windows of the
    // pixel they will hit; frame start mostly marks address zero.
    task automatic random_pixel();
        bit          start;
        int unsigned a;
        int          b;
        int          d;
        int          off;
        int          rng;
        bit [7:0]    mask;
        if (sb.addr_of(1'b0) == 0) start = ($urandom_range(99) < 90);
        else                       start = ($urandom_range(99) < 3);
        a   = sb.addr_of(start);
        b   = int'(sb.bg_mem[a]);
        off = int'(sb.offset);
        rng = int'(sb.range_d);
        case ($urandom_range(9))
            1:       d = $urandom_range(1) ? 65535 : 0;
            2:       d = int'(sb.cutoff) + int'($urandom_range(2)) - 1;
            3:       d = b - off + int'($urandom_range(2)) - 1;
            4:       d = b - off - rng + int'($urandom_range(2)) - 1;
            5:       d = b - off - int'($urandom_range(rng));
            6:       d = b + off + int'($urandom_range(2)) - 1;
            7:       d = b + int'($urandom_range(4)) - 2;
            default: d = $urandom_range(65535);
        endcase
        if (d < 0) d = 0;
        if (d > 65535) d = 65535;
        case ($urandom_range(5))
            0:       mask = MASK_THRESHOLD;
            1:       mask = MASK_THRESHOLD + 8'd1;
            2:       mask = MASK_THRESHOLD - 8'd1;
            3:       mask = $urandom_range(1) ? 8'hFF : 8'h00;
            default: mask = 8'($urandom);
        endcase
        send_pixel(16'(d), mask, start);
    endtask

    task automatic random_phase(int idx);
        mode_t                 m;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        logic [CFG_DATA_W-1:0] cut;
        logic [CFG_DATA_W-1:0] off;
        logic [CFG_DATA_W-1:0] rng;
        int                    k;
        k = $urandom_range(99);
        m = (k < 10) ? MODE_CLEAR : (k < 35) ? MODE_LEARN : (k < 70) ? MODE_ACTIVE : MODE_CHANGE;
        case ($urandom_range(9))
            7: begin
                w = 13'($urandom_range(1023, 0));
                h = 13'd1;
            end
            8: begin
                w = 13'd1;
                h = 13'($urandom_range(1023, 0));
            end
            9: begin
                w = 13'($urandom_range(3, 0));
                h = 13'($urandom_range(4, 0));
            end
            default: begin
                w = 13'($urandom_range(8, 1));
                h = 13'($urandom_range(6, 1));
            end
        endcase
        // Bits above the register width must be dropped by the block.
        if ($urandom_range(4) == 0) w[12:10] = 3'($urandom_range(7));
        if ($urandom_range(4) == 0) h[12:10] = 3'($urandom_range(7));
        cut = ($urandom_range(1) != 0) ? 13'($urandom_range(3000, 0))
                                       : 13'($urandom_range(8191, 0));
        off = ($urandom_range(1) != 0) ? 13'($urandom_range(20, 0))
                                       : 13'($urandom_range(511, 0));
        case ($urandom_range(4))
            0:       rng = $urandom_range(1) ? 13'd0 : 13'd1;
            1:       rng = 13'd8191;
            default: rng = 13'($urandom_range(8191, 0));
        endcase
        case (idx % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 66; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 66; end
            default: begin idle_pct = 35; stall_pct = 35; end
        endcase
        apply_settings(m, w, h, cut, off, rng);
        for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (idx == 3 && i == ITEMS_PER_PHASE / 2) wait_idle();
            random_pixel();
        end
    endtask

    initial begin
        sb = new();
        reg_shadow[REG_MODE]   = 13'(MODE_LEARN);
        reg_shadow[REG_WIDTH]  = 13'(RST_WIDTH);
        reg_shadow[REG_HEIGHT] = 13'(RST_HEIGHT);
        reg_shadow[REG_CUTOFF] = 13'(RST_CUTOFF);
        reg_shadow[REG_OFFSET] = 13'(RST_OFFSET);
        reg_shadow[REG_RANGE]  = 13'(RST_RANGE);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Learn on a 4x2 frame with the reset thresholds: the cutoff itself is
        // not learned, a full-scale depth is not nearer than a cleared entry.
        apply_settings(MODE_LEARN, 13'd4, 13'd2, 13'(RST_CUTOFF), 13'(RST_OFFSET),
                       13'(RST_RANGE));
        send_pixel(16'hFFFF, 8'h00, 1'b1);
        send_pixel(16'd4000, 8'hFF, 1'b0);
        send_pixel(16'd4001, 8'd128, 1'b0);
        send_pixel(16'd0,    8'd129, 1'b0);
        send_pixel(16'd6000, 8'h00, 1'b0);
        send_pixel(16'd6500, 8'h00, 1'b0);
        send_pixel(16'd7000, 8'h00, 1'b0);
        send_pixel(16'd8000, 8'h00, 1'b0);
        // Two frame starts in a row hit the same entry back to back.
        send_pixel(16'd5000, 8'h00, 1'b1);
        send_pixel(16'd4999, 8'h00, 1'b1);

        // Active detection at the edges of the slab and of the mask threshold.
        apply_settings(MODE_ACTIVE, 13'd4, 13'd2, 13'(RST_CUTOFF), 13'(RST_OFFSET),
                       13'(RST_RANGE));
        send_pixel(16'd4988,  8'd129, 1'b1);
        send_pixel(16'd65524, 8'd128, 1'b0);
        send_pixel(16'd4001,  8'hFF,  1'b0);
        send_pixel(16'd64525, 8'hFF,  1'b0);
        send_pixel(16'd5989,  8'hFF,  1'b0);
        send_pixel(16'd5490,  8'hFF,  1'b0);
        send_pixel(16'd6989,  8'd127, 1'b0);
        send_pixel(16'd7990,  8'hFF,  1'b0);

        // Oversized width and zero height saturate; a zero offset always fires.
        apply_settings(MODE_CHANGE, 13'd1023, 13'd0, 13'(RST_CUTOFF), 13'd0, 13'(RST_RANGE));
        send_pixel(16'hFFFF, 8'h00, 1'b1);
        send_pixel(16'd0,    8'h00, 1'b0);

        apply_settings(MODE_CHANGE, 13'd0, 13'd1023, 13'd0, 13'd511, 13'd8191);
        send_pixel(16'd65024, 8'h00, 1'b1);
        send_pixel(16'd65025, 8'h00, 1'b0);
        send_pixel(16'd0,     8'hFF, 1'b0);

        // The frame shrinks below the counter: the next pixel lands on address zero.
        apply_settings(MODE_ACTIVE, 13'd1, 13'd2, 13'd0, 13'd511, 13'd0);
        send_pixel(16'd100,   8'hFF, 1'b0);
        send_pixel(16'd65000, 8'hFF, 1'b0);

        apply_settings(MODE_ACTIVE, 13'd1, 13'd2, 13'd8191, 13'd0, 13'd8191);
        send_pixel(16'd65534, 8'hFF, 1'b1);

        for (int p = 0; p < RAND_PHASES; p++)
            random_phase(p);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS depth_background_foreground");
        else
            $display("FAIL depth_background_foreground");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/dbf_pkg.sv
design/dbf_bg_ram.sv
design/dbf_frame_ctr.sv
design/dbf_pixel_eval.sv
design/depth_background_foreground.sv
test/tb_top.sv
